/* src/piecewise_linear_colormap_core_defines.svh */
// assertion macros shared by the colormap checker
`ifndef PIECEWISE_LINEAR_COLORMAP_CORE_DEFINES_SVH
`define PIECEWISE_LINEAR_COLORMAP_CORE_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define PLC_ASSERT_IMPLY(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("colormap check failed in the same cycle");

// condition holds in the cycle after the trigger
`define PLC_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("colormap check failed one cycle later");

`endif

/* src/plc_pkg.sv */
// types, constants and helpers of the piecewise linear colormap
package plc_pkg;

    localparam int MAX_POINTS = 7;
    localparam int MIN_POINTS = 2;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = 3;
    localparam int VAL_W      = 16;
    localparam int COL_W      = 8;
    localparam int NUM_CH     = 3;
    localparam int CH_W       = 2;
    localparam int PROD_W     = VAL_W + COL_W;
    localparam int NUM_W      = PROD_W + 1;
    // divisor is twice the segment width, pre-shifted for an 8-bit quotient
    localparam int DSH_W      = VAL_W + COL_W;
    localparam int STEP_W     = $clog2(2 * NUM_CH);
    localparam int QCNT_W     = $clog2(COL_W);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_FIRST = 3'd1;

    // channel lanes
    localparam logic [CH_W-1:0] CH_RED   = 2'd0;
    localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
    localparam logic [CH_W-1:0] CH_BLUE  = 2'd2;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [COL_W-1:0] red;
        logic [COL_W-1:0] green;
        logic [COL_W-1:0] blue;
    } point_t;

    typedef logic [NUM_CH-1:0][COL_W-1:0] color_t;

    typedef struct packed {
        logic                             start;
        logic [VAL_W-1:0]                 den;
        logic [NUM_CH-1:0][NUM_W-1:0]     num;
    } div_req_t;

    typedef struct packed {
        logic   done;
        color_t quo;
    } div_res_t;

    function automatic logic [COL_W-1:0] point_chan(point_t p, logic [CH_W-1:0] ch);
        logic [COL_W-1:0] c;
        unique case (ch)
            CH_RED:   c = p.red;
            CH_GREEN: c = p.green;
            default:  c = p.blue;
        endcase
        return c;
    endfunction

endpackage

/* src/piecewise_linear_colormap_core.sv */
// piecewise linear colormap: breakpoint search, shared multiplier, iterative divider
//
//  channel   direction  handshake                payload
//  sample    in         sample_valid/stall       sample
//  color     out        color_valid/stall        red, green, blue
//  cfg       in         cfg_valid/cfg_ready      cfg_index, cfg_data
//
// the search compares the sample with one breakpoint per cycle
// an interior sample then takes a multiply-accumulate step for each channel
// and endpoint on the one 8x16 multiplier, then a three-lane division
// a sample outside every segment takes the color of the first or last breakpoint
// one item at a time; sample_stall is high from acceptance until the result loads
// the color register holds a result under color_stall while the next item is taken
// rst_n clears control state and restores the breakpoint table
module piecewise_linear_colormap_core
    import plc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  logic [VAL_W-1:0]      sample,
    output logic                  color_valid,
    input  logic                  color_stall,
    output logic [COL_W-1:0]      red,
    output logic [COL_W-1:0]      green,
    output logic [COL_W-1:0]      blue,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t                       state_reg;
    logic [CNT_W-1:0]             count_reg;
    point_t                       point_reg [MAX_POINTS];
    logic [IDX_W-1:0]             idx_reg;
    logic [VAL_W-1:0]             sample_reg;
    point_t                       lo_reg;
    point_t                       hi_reg;
    logic [VAL_W-1:0]             w_reg;
    logic [VAL_W-1:0]             t_reg;
    logic [VAL_W-1:0]             den_reg;
    logic [STEP_W-1:0]            step_reg;
    logic [NUM_CH-1:0][PROD_W-1:0] acc_reg;
    color_t                       res_reg;
    logic                         start_reg;
    logic                         out_valid_reg;
    color_t                       out_reg;

    logic [IDX_W-1:0]             last_idx;
    logic [CFG_IDX_W-1:0]         wr_idx;
    point_t                       cur;
    logic                         below;
    logic [CH_W-1:0]              mul_ch;
    logic [COL_W-1:0]             mul_col;
    logic [VAL_W-1:0]             mul_fac;
    logic [PROD_W-1:0]            prod;
    logic                         out_free;
    div_req_t                     div_req;
    div_res_t                     div_res;

    // configuration registers
    assign cfg_ready = 1'b1;
    assign wr_idx    = cfg_index - CFG_POINT_FIRST;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CNT_W'(MIN_POINTS);
            for (int i = 0; i < MAX_POINTS; i++)
            begin
                point_reg[i] <= (i == 1) ? '1 : '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_POINT_COUNT)
            begin
                count_reg <= cfg_data[CNT_W-1:0];
            end
            else if (wr_idx < CFG_IDX_W'(MAX_POINTS))
            begin
                point_reg[wr_idx[IDX_W-1:0]] <= cfg_data;
            end
        end
    end

    // count clamped to the supported range
    always_comb
    begin
        priority if (count_reg < CNT_W'(MIN_POINTS))
        begin
            last_idx = IDX_W'(MIN_POINTS - 1);
        end
        else if (count_reg > CNT_W'(MAX_POINTS))
        begin
            last_idx = IDX_W'(MAX_POINTS - 1);
        end
        else
        begin
            last_idx = IDX_W'(count_reg - 1'b1);
        end
    end

    assign cur   = point_reg[idx_reg];
    assign below = sample_reg < cur.value;

    // shared multiplier: even steps c0*(v1-v), odd steps c1*(v-v0)
    assign mul_ch  = step_reg[STEP_W-1:1];
    assign mul_col = step_reg[0] ? point_chan(hi_reg, mul_ch) : point_chan(lo_reg, mul_ch);
    assign mul_fac = step_reg[0] ? t_reg : w_reg;
    assign prod    = PROD_W'(mul_col) * PROD_W'(mul_fac);

    // numerator 2*(c0*(v1-v) + c1*(v-v0)) + den over divisor 2*den rounds half up
    always_comb
    begin
        div_req.start = start_reg;
        div_req.den   = den_reg;
        for (int i = 0; i < NUM_CH; i++)
        begin
            div_req.num[i] = {acc_reg[i], 1'b0} + NUM_W'(den_reg);
        end
    end

    plc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res)
    );

    assign out_free = !out_valid_reg || !color_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            step_reg      <= '0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            if (out_valid_reg && !color_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (sample_valid)
                    begin
                        sample_reg <= sample;
                        idx_reg    <= '0;
                        state_reg  <= ST_SEARCH;
                    end
                end
                ST_SEARCH:
                begin
                    priority if (below && idx_reg == '0)
                    begin
                        res_reg   <= {cur.blue, cur.green, cur.red};
                        state_reg <= ST_OUT;
                    end
                    else if (below)
                    begin
                        hi_reg    <= cur;
                        w_reg     <= cur.value - sample_reg;
                        t_reg     <= sample_reg - lo_reg.value;
                        den_reg   <= cur.value - lo_reg.value;
                        acc_reg   <= '0;
                        step_reg  <= '0;
                        state_reg <= ST_MUL;
                    end
                    else if (idx_reg == last_idx)
                    begin
                        res_reg   <= {cur.blue, cur.green, cur.red};
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        lo_reg  <= cur;
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_MUL:
                begin
                    acc_reg[mul_ch] <= acc_reg[mul_ch] + prod;
                    step_reg        <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(2 * NUM_CH - 1))
                    begin
                        start_reg <= 1'b1;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_res.done)
                    begin
                        res_reg   <= div_res.quo;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_reg       <= res_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign sample_stall = state_reg != ST_IDLE;
    assign color_valid  = out_valid_reg;
    assign red          = out_reg[CH_RED];
    assign green        = out_reg[CH_GREEN];
    assign blue         = out_reg[CH_BLUE];

endmodule

/* src/plc_div.sv */
// three-lane restoring divider, one quotient bit per cycle, shared divisor
module plc_div
    import plc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_res_t res
);

    logic                         busy_reg;
    logic                         done_reg;
    logic [QCNT_W-1:0]            cnt_reg;
    logic [DSH_W-1:0]             dsh_reg;
    logic [NUM_CH-1:0][NUM_W-1:0] rem_reg;
    color_t                       quo_reg;

    logic [NUM_CH-1:0]            ge;

    always_comb
    begin
        for (int i = 0; i < NUM_CH; i++)
        begin
            ge[i] = rem_reg[i] >= NUM_W'(dsh_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == QCNT_W'(COL_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            // 2*den aligned to the top quotient bit
            dsh_reg <= {req.den, {COL_W{1'b0}}};
            rem_reg <= req.num;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            dsh_reg <= dsh_reg >> 1;
            for (int i = 0; i < NUM_CH; i++)
            begin
                if (ge[i])
                begin
                    rem_reg[i] <= rem_reg[i] - NUM_W'(dsh_reg);
                end
                quo_reg[i] <= {quo_reg[i][COL_W-2:0], ge[i]};
            end
        end
    end

    assign res.done = done_reg;
    assign res.quo  = quo_reg;

endmodule

/* src/plc_checker.sv */
// port-level checks of the colormap core, bound to the top level
`include "piecewise_linear_colormap_core_defines.svh"

module plc_checker
    import plc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  sample_valid,
    input logic                  sample_stall,
    input logic [VAL_W-1:0]      sample,
    input logic                  color_valid,
    input logic                  color_stall,
    input logic [COL_W-1:0]      red,
    input logic [COL_W-1:0]      green,
    input logic [COL_W-1:0]      blue,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    // a stalled result keeps its value
    `PLC_ASSERT_NEXT(a_result_hold, clk, rst_n, color_valid && color_stall, color_valid && $stable(red) && $stable(green) && $stable(blue))

    // one request at a time: busy right after acceptance
    `PLC_ASSERT_NEXT(a_busy_after_request, clk, rst_n, sample_valid && !sample_stall, sample_stall)

    // a new result only comes out of a request in flight
    `PLC_ASSERT_IMPLY(a_result_from_request, clk, rst_n, $rose(color_valid), $past(sample_stall))

endmodule

bind piecewise_linear_colormap_core plc_checker u_plc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .color_valid  (color_valid),
    .color_stall  (color_stall),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
);
